// ===== rtl/core/rv32_dec_pkg.sv =====
// Types, opcode constants and a helper function for the RV32I instruction decoder.
package rv32_dec_pkg;

  // Major opcodes (instruction bits 6:0)
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  // funct7 values that pick the base or the alternate operation
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // funct3 codes that matter to the decoder
  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SR  = 3'd5;

  // SYSTEM immediates
  localparam logic [11:0] SYS_ECALL  = 12'h000;
  localparam logic [11:0] SYS_EBREAK = 12'h001;

  typedef enum logic [2:0] {
    CLS_R     = 3'd0,
    CLS_I     = 3'd1,
    CLS_S     = 3'd2,
    CLS_B     = 3'd3,
    CLS_U     = 3'd4,
    CLS_J     = 3'd5,
    CLS_UNSUP = 3'd6
  } inst_class_e;

  typedef enum logic [3:0] {
    ALU_NOP  = 4'd0,
    ALU_ADD  = 4'd1,
    ALU_SUB  = 4'd2,
    ALU_SLL  = 4'd3,
    ALU_SLT  = 4'd4,
    ALU_SLTU = 4'd5,
    ALU_XOR  = 4'd6,
    ALU_SRL  = 4'd7,
    ALU_SRA  = 4'd8,
    ALU_OR   = 4'd9,
    ALU_AND  = 4'd10
  } alu_op_e;

  typedef enum logic [2:0] {
    MEM_NONE   = 3'd0,
    MEM_LOAD   = 3'd1,
    MEM_STORE  = 3'd2,
    MEM_ECALL  = 3'd3,
    MEM_EBREAK = 3'd4
  } mem_op_e;

  // One decoded instruction
  typedef struct packed {
    inst_class_e inst_class;
    logic [6:0]  opcode_bits;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [2:0]  func3_field;
    logic [6:0]  func7_field;
    logic [31:0] left_operand;
    logic [31:0] right_operand;
    logic [31:0] disp_value;
    alu_op_e     alu_code;
    mem_op_e     mem_code;
  } dec_res_t;

  // Base operation selected by funct3 alone
  function automatic alu_op_e base_op(input logic [2:0] f3);
    alu_op_e op;
    unique case (f3)
      3'd0:    op = ALU_ADD;
      3'd1:    op = ALU_SLL;
      3'd2:    op = ALU_SLT;
      3'd3:    op = ALU_SLTU;
      3'd4:    op = ALU_XOR;
      3'd5:    op = ALU_SRL;
      3'd6:    op = ALU_OR;
      default: op = ALU_AND;
    endcase
    return op;
  endfunction

endpackage

// ===== rtl/core/rv32i_instruction_decoder_top.sv =====
// RV32I instruction decoder: input word register, decode logic, result register.
//
// Slave channel (s_axis_*) carries one instruction word per transfer: the raw
// instruction, the program counter already advanced by four, and the two
// register-file values read at instruction bits 19:15 and 24:20.
// Master channel (m_axis_*) returns one decoded word per input word, in
// order: class on tuser, fields, ALU operands, displacement and op codes in
// tdata.
// A word taken on the slave side sits in the input register, is decoded
// combinationally and lands in the result register, from which it is
// presented on the master side. Throughput is one word per cycle while the
// receiver takes every output word.
// When the receiver stalls, the result register holds its word and the
// input register can still fill, so up to two words are held; the slave
// tready drops only when both stages are full and the output is not taken.
// Reset clears both stage valid flags; no word is presented until an input
// word has been accepted.
module rv32i_instruction_decoder_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input word
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] instruction_word, [63:32] pc_after_fetch, [95:64] rs1_value,
  // [127:96] rs2_value
  input  logic [127:0] s_axis_tdata,
  // Output word
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [6:0] opcode_bits, [11:7] dest_reg, [16:12] src1_reg, [21:17] src2_reg,
  // [24:22] func3_field, [31:25] func7_field, [63:32] left_operand,
  // [95:64] right_operand, [127:96] disp_value, [131:128] alu_code,
  // [134:132] mem_code, [135] zero
  output logic [135:0] m_axis_tdata,
  // [2:0] inst_class
  output logic [2:0]   m_axis_tuser
);

  // Stage registers
  logic                  in_valid_q;
  logic [127:0]          in_word_q;
  logic                  out_valid_q;
  rv32_dec_pkg::dec_res_t res_q;
  rv32_dec_pkg::dec_res_t res_d;

  logic out_ready;
  logic in_ready;

  // Pipeline flow control
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign in_ready      = !in_valid_q || out_ready;
  assign s_axis_tready = in_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_word_q <= s_axis_tdata;
    end
  end

  // Field extraction
  logic [31:0] w;
  logic [31:0] pc;
  logic [31:0] v1;
  logic [31:0] v2;
  logic [6:0]  opc;
  logic [4:0]  rdf;
  logic [2:0]  f3f;
  logic [4:0]  r1f;
  logic [4:0]  r2f;
  logic [6:0]  f7f;
  logic [11:0] i12;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm_j;
  logic [31:0] shamt;
  logic [31:0] pc_cur;

  assign w      = in_word_q[31:0];
  assign pc     = in_word_q[63:32];
  assign v1     = in_word_q[95:64];
  assign v2     = in_word_q[127:96];
  assign opc    = w[6:0];
  assign rdf    = w[11:7];
  assign f3f    = w[14:12];
  assign r1f    = w[19:15];
  assign r2f    = w[24:20];
  assign f7f    = w[31:25];
  assign i12    = w[31:20];
  assign imm_i  = {{20{w[31]}}, w[31:20]};
  assign imm_s  = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b  = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_u  = {w[31:12], 12'h000};
  assign imm_j  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign shamt  = {27'd0, w[24:20]};
  assign pc_cur = pc - 32'd4;

  // Decode
  always_comb begin
    res_d               = '0;
    res_d.inst_class    = rv32_dec_pkg::CLS_UNSUP;
    res_d.opcode_bits   = opc;
    res_d.alu_code      = rv32_dec_pkg::ALU_NOP;
    res_d.mem_code      = rv32_dec_pkg::MEM_NONE;
    unique case (opc)
      rv32_dec_pkg::OPC_OP: begin
        res_d.inst_class    = rv32_dec_pkg::CLS_R;
        res_d.dest_reg      = rdf;
        res_d.src1_reg      = r1f;
        res_d.src2_reg      = r2f;
        res_d.func3_field   = f3f;
        res_d.func7_field   = f7f;
        res_d.left_operand  = v1;
        res_d.right_operand = v2;
        if (f7f == rv32_dec_pkg::F7_BASE) begin
          res_d.alu_code = rv32_dec_pkg::base_op(f3f);
        end else if (f7f == rv32_dec_pkg::F7_ALT && f3f == rv32_dec_pkg::F3_ADD) begin
          res_d.alu_code = rv32_dec_pkg::ALU_SUB;
        end else if (f7f == rv32_dec_pkg::F7_ALT && f3f == rv32_dec_pkg::F3_SR) begin
          res_d.alu_code = rv32_dec_pkg::ALU_SRA;
        end
      end
      rv32_dec_pkg::OPC_OP_IMM: begin
        res_d.inst_class   = rv32_dec_pkg::CLS_I;
        res_d.dest_reg     = rdf;
        res_d.src1_reg     = r1f;
        res_d.func3_field  = f3f;
        res_d.left_operand = v1;
        if (f3f == rv32_dec_pkg::F3_SLL || f3f == rv32_dec_pkg::F3_SR) begin
          // Shift by immediate: 5-bit amount, funct7 kept
          res_d.func7_field   = f7f;
          res_d.right_operand = shamt;
          res_d.disp_value    = shamt;
          if (f7f == rv32_dec_pkg::F7_BASE) begin
            res_d.alu_code = rv32_dec_pkg::base_op(f3f);
          end else if (f7f == rv32_dec_pkg::F7_ALT && f3f == rv32_dec_pkg::F3_SR) begin
            res_d.alu_code = rv32_dec_pkg::ALU_SRA;
          end
        end else begin
          res_d.right_operand = imm_i;
          res_d.disp_value    = imm_i;
          res_d.alu_code      = rv32_dec_pkg::base_op(f3f);
        end
      end
      rv32_dec_pkg::OPC_LOAD: begin
        res_d.inst_class    = rv32_dec_pkg::CLS_I;
        res_d.dest_reg      = rdf;
        res_d.src1_reg      = r1f;
        res_d.func3_field   = f3f;
        res_d.left_operand  = v1;
        res_d.right_operand = imm_i;
        res_d.disp_value    = imm_i;
        res_d.alu_code      = rv32_dec_pkg::ALU_ADD;
        res_d.mem_code      = rv32_dec_pkg::MEM_LOAD;
      end
      rv32_dec_pkg::OPC_STORE: begin
        res_d.inst_class    = rv32_dec_pkg::CLS_S;
        res_d.src1_reg      = r1f;
        res_d.src2_reg      = r2f;
        res_d.func3_field   = f3f;
        res_d.left_operand  = v1;
        res_d.right_operand = imm_s;
        res_d.disp_value    = v2;
        res_d.alu_code      = rv32_dec_pkg::ALU_ADD;
        res_d.mem_code      = rv32_dec_pkg::MEM_STORE;
      end
      rv32_dec_pkg::OPC_BRANCH: begin
        res_d.inst_class    = rv32_dec_pkg::CLS_B;
        res_d.src1_reg      = r1f;
        res_d.src2_reg      = r2f;
        res_d.func3_field   = f3f;
        res_d.left_operand  = v1;
        res_d.right_operand = v2;
        res_d.disp_value    = imm_b;
        // beq/bne compare by subtract, blt/bge signed, bltu/bgeu unsigned
        unique case (f3f)
          3'd0, 3'd1: res_d.alu_code = rv32_dec_pkg::ALU_SUB;
          3'd4, 3'd5: res_d.alu_code = rv32_dec_pkg::ALU_SLT;
          3'd6, 3'd7: res_d.alu_code = rv32_dec_pkg::ALU_SLTU;
          default:    res_d.alu_code = rv32_dec_pkg::ALU_NOP;
        endcase
      end
      rv32_dec_pkg::OPC_LUI: begin
        res_d.inst_class    = rv32_dec_pkg::CLS_U;
        res_d.dest_reg      = rdf;
        res_d.right_operand = imm_u;
        res_d.disp_value    = imm_u;
        res_d.alu_code      = rv32_dec_pkg::ALU_ADD;
      end
      rv32_dec_pkg::OPC_AUIPC: begin
        res_d.inst_class    = rv32_dec_pkg::CLS_U;
        res_d.dest_reg      = rdf;
        res_d.left_operand  = pc_cur;
        res_d.right_operand = imm_u;
        res_d.disp_value    = imm_u;
        res_d.alu_code      = rv32_dec_pkg::ALU_ADD;
      end
      rv32_dec_pkg::OPC_JAL: begin
        res_d.inst_class    = rv32_dec_pkg::CLS_J;
        res_d.dest_reg      = rdf;
        res_d.left_operand  = pc_cur;
        res_d.right_operand = imm_j;
        res_d.disp_value    = imm_j;
        res_d.alu_code      = rv32_dec_pkg::ALU_ADD;
      end
      rv32_dec_pkg::OPC_JALR: begin
        res_d.inst_class    = rv32_dec_pkg::CLS_I;
        res_d.dest_reg      = rdf;
        res_d.src1_reg      = r1f;
        res_d.func3_field   = f3f;
        res_d.left_operand  = v1;
        res_d.right_operand = imm_i;
        res_d.disp_value    = imm_i;
        res_d.alu_code      = rv32_dec_pkg::ALU_ADD;
      end
      rv32_dec_pkg::OPC_SYSTEM: begin
        res_d.inst_class  = rv32_dec_pkg::CLS_I;
        res_d.dest_reg    = rdf;
        res_d.src1_reg    = r1f;
        res_d.func3_field = f3f;
        if (i12 == rv32_dec_pkg::SYS_ECALL) begin
          res_d.mem_code = rv32_dec_pkg::MEM_ECALL;
        end else if (i12 == rv32_dec_pkg::SYS_EBREAK) begin
          res_d.mem_code = rv32_dec_pkg::MEM_EBREAK;
        end
      end
      default: begin
        // unsupported opcode: defaults stand
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      res_q <= res_d;
    end
  end

  // Output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.inst_class;
  assign m_axis_tdata  = {1'b0,
                          res_q.mem_code,
                          res_q.alu_code,
                          res_q.disp_value,
                          res_q.right_operand,
                          res_q.left_operand,
                          res_q.func7_field,
                          res_q.func3_field,
                          res_q.src2_reg,
                          res_q.src1_reg,
                          res_q.dest_reg,
                          res_q.opcode_bits};

  // Unsupported opcodes carry no operation
  a_unsup_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.inst_class == rv32_dec_pkg::CLS_UNSUP) |->
      (res_q.alu_code == rv32_dec_pkg::ALU_NOP &&
       res_q.mem_code == rv32_dec_pkg::MEM_NONE &&
       res_q.dest_reg == 5'd0))
    else $error("unsupported opcode produced an operation");

  // Environment calls only come from SYSTEM instructions
  a_sys_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.mem_code == rv32_dec_pkg::MEM_ECALL ||
                     res_q.mem_code == rv32_dec_pkg::MEM_EBREAK)) |->
      (res_q.opcode_bits == rv32_dec_pkg::OPC_SYSTEM &&
       res_q.inst_class == rv32_dec_pkg::CLS_I))
    else $error("ecall/ebreak from a non-SYSTEM opcode");

  // Backpressure reaches the input only with both stages full
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while a stage was free");

endmodule
